>>> rtl/sbda_pkg.sv
package sbda_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned CHAR_W    = 7;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
	localparam int unsigned NDIG_W    = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_DABBLE,
		OP_SHIFT
	} cell_op_t;

endpackage

>>> rtl/sbda_cell.sv
module sbda_cell (
	input  logic                    clk,
	input  sbda_pkg::cell_op_t      op,
	input  logic                    bit_in,
	input  logic [3:0]              digit_in,
	output logic                    carry_out,
	output logic [3:0]              digit
);
	import sbda_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] corr;

	// add-3 correction ahead of the shift
	assign corr      = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = corr[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_HOLD:   digit_q <= digit_q;
			OP_CLEAR:  digit_q <= '0;
			OP_DABBLE: digit_q <= {corr[2:0], bit_in};
			OP_SHIFT:  digit_q <= digit_in;
		endcase
	end

endmodule

>>> rtl/signed_binary_to_decimal_ascii.sv
// Prints a signed 32-bit value as decimal ASCII, most significant character first, with a
// leading '-' for negative values and no leading zeros; last marks the final character.
// One value is in flight at a time: value_stall stays high from acceptance until the final
// character has been loaded into the output register. An accepted value is converted
// bit by bit by shift-and-add-3 through a row of ten BCD digit cells, the leading zero
// digits are dropped, keeping at least one, then one character is emitted per cycle
// while result_stall stays low. Dropped zeros and printed digits always make ten.
module signed_binary_to_decimal_ascii (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              value_valid,
	output logic                              value_stall,
	input  logic signed [sbda_pkg::VALUE_W-1:0] value,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [sbda_pkg::CHAR_W-1:0]       character,
	output logic                              last
);
	import sbda_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [NDIG_W-1:0]    ndig_q;
	logic                 result_valid_q;
	logic [CHAR_W-1:0]    character_q;
	logic                 last_q;

	logic [VALUE_W-1:0]   mag_next;
	logic                 accept;
	logic                 out_free;
	logic                 skip_digit;
	cell_op_t             op;

	logic [DIGIT_W-1:0]   digit [NUM_DIGITS];
	logic                 carry [NUM_DIGITS];
	logic [DIGIT_W-1:0]   top_digit;

	assign accept     = value_valid && !value_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign top_digit  = digit[NUM_DIGITS-1];
	assign skip_digit = (top_digit == '0) && (ndig_q > NDIG_W'(1));
	assign mag_next   = value[VALUE_W-1] ? (~$unsigned(value) + VALUE_W'(1)) : $unsigned(value);

	assign value_stall  = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign character    = character_q;
	assign last         = last_q;

	always_comb begin
		op = OP_HOLD;
		case (state_q)
			ST_IDLE: if (accept) op = OP_CLEAR;
			ST_CONV: op = OP_DABBLE;
			ST_SKIP: if (skip_digit) op = OP_SHIFT;
			ST_EMIT: if (out_free && !neg_q) op = OP_SHIFT;
			default: op = OP_HOLD;
		endcase
	end

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic                bit_in;
		logic [DIGIT_W-1:0]  digit_in;

		if (i == 0) begin : g_low
			assign bit_in   = mag_q[VALUE_W-1];
			assign digit_in = '0;
		end else begin : g_up
			assign bit_in   = carry[i-1];
			assign digit_in = digit[i-1];
		end

		sbda_cell u_cell (
			.clk       (clk),
			.op        (op),
			.bit_in    (bit_in),
			.digit_in  (digit_in),
			.carry_out (carry[i]),
			.digit     (digit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			neg_q          <= 1'b0;
			bit_cnt_q      <= '0;
			ndig_q         <= '0;
			result_valid_q <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q     <= value[VALUE_W-1];
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
						ndig_q  <= NDIG_W'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_digit)
						ndig_q <= ndig_q - NDIG_W'(1);
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (neg_q) begin
							neg_q  <= 1'b0;
							last_q <= 1'b0;
						end else begin
							ndig_q <= ndig_q - NDIG_W'(1);
							last_q <= (ndig_q == NDIG_W'(1));
							if (ndig_q == NDIG_W'(1))
								state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	// character payload needs no reset
	always_ff @(posedge clk) begin
		if (accept)
			mag_q <= mag_next;
		else if (state_q == ST_CONV)
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		if (state_q == ST_EMIT && out_free)
			character_q <= neg_q ? CHAR_MINUS : CHAR_ZERO + CHAR_W'(top_digit);
	end

`ifndef SYNTHESIS
	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (ndig_q != '0))
		else $error("emitting with no digits left");

	a_digit_is_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top_digit <= DIGIT_W'(9)))
		else $error("conversion produced a non-decimal digit");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && character == CHAR_MINUS) |-> !last)
		else $error("minus sign marked as final character");

	a_conv_no_output_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && !result_valid) |=> !result_valid)
		else $error("character produced during conversion");
`endif

endmodule

>>> test/signed_binary_to_decimal_ascii_test.sv
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_test;

	localparam int IDLE_LIMIT    = 5000;
	localparam int HOLDOFF_LEN   = 300;
	localparam int HOLDOFF_AFTER = 1500;
	localparam int RANDOM_VALUES = 480;

	typedef struct packed {
		logic [sbda_pkg::CHAR_W-1:0] character;
		logic                        last;
	} text_char_t;

	typedef struct {
		logic signed [sbda_pkg::VALUE_W-1:0] value;
		bit                                  after_drain;
	} pending_value_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic value_valid = 1'b0;
	logic value_stall;
	logic signed [sbda_pkg::VALUE_W-1:0] value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [sbda_pkg::CHAR_W-1:0] character;
	logic last;

	pending_value_t values_to_send[$];
	text_char_t     text_expected[$];

	logic drained = 1'b1;
	logic calm = 1'b0;
	int   values_sent = 0;
	int   negatives_sent = 0;
	int   chars_checked = 0;
	int   mismatches = 0;
	int   holdoff_left = 0;
	bit   holdoff_done = 1'b0;
	int   idle_cycles = 0;

	signed_binary_to_decimal_ascii dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.value_valid  (value_valid),
		.value_stall  (value_stall),
		.value        (value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.character    (character),
		.last         (last)
	);

	always #10 clk = ~clk;

	// decimal text of one value, most significant character first
	function automatic void queue_decimal_text(input logic [sbda_pkg::VALUE_W-1:0] bits);
		logic [sbda_pkg::VALUE_W-1:0] magnitude;
		logic [3:0] digit_buf[sbda_pkg::NUM_DIGITS];
		int count;
		text_char_t c;
		count = 0;
		if (bits[sbda_pkg::VALUE_W-1]) begin
			c.character = sbda_pkg::CHAR_MINUS;
			c.last = 1'b0;
			text_expected.push_back(c);
			magnitude = ~bits + 1'b1;
		end else begin
			magnitude = bits;
		end
		do begin
			digit_buf[count] = 4'(magnitude % 10);
			count++;
			magnitude = magnitude / 10;
		end while (magnitude != 0 && count < sbda_pkg::NUM_DIGITS);
		for (int i = count - 1; i >= 0; i--) begin
			c.character = sbda_pkg::CHAR_ZERO + 7'(digit_buf[i]);
			c.last = (i == 0);
			text_expected.push_back(c);
		end
	endfunction

	always @(negedge clk) begin
		drained <= (text_expected.size() == 0);
	end

	// driver
	always @(posedge clk) begin
		pending_value_t next_item;
		if (arst_n) begin
			if (value_valid && !value_stall) begin
				queue_decimal_text(value);
				values_sent <= values_sent + 1;
				if (value < 0)
					negatives_sent <= negatives_sent + 1;
			end
			calm <= (values_sent >= 300 && values_sent < 380);
			if (!value_valid || !value_stall) begin
				if (values_to_send.size() != 0
						&& (!values_to_send[0].after_drain || (drained && !value_valid))
						&& (calm || $urandom_range(0, 99) >= 28)) begin
					next_item = values_to_send.pop_front();
					value_valid <= 1'b1;
					value <= next_item.value;
				end else begin
					value_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				chars_checked <= chars_checked + 1;
				if (text_expected.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected character %0d last %0b", $time, character, last);
					mismatches++;
				end else begin
					want = text_expected.pop_front();
					if (character !== want.character || last !== want.last) begin
						if (mismatches < 10)
							$display("%0t: character %0d last %0b, expected %0d last %0b",
								$time, character, last, want.character, want.last);
						mismatches++;
					end
				end
			end
			if (holdoff_left != 0) begin
				holdoff_left <= holdoff_left - 1;
				result_stall <= 1'b1;
			end else if (!holdoff_done && chars_checked >= HOLDOFF_AFTER) begin
				holdoff_done <= 1'b1;
				holdoff_left <= HOLDOFF_LEN;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !calm && ($urandom_range(0, 99) < 28);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_valid && !value_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic signed [31:0] directed[22];
		pending_value_t item;
		longint lo;
		longint hi;
		longint mag;
		int n;

		directed = '{
			0, 1, -1, 7, -5, 9, 10, -10, 99, 100,
			2147483647, 32'sh80000000, -2147483647, 1000000000, -1000000000,
			999999999, -999999999, 123456789, -123456789, 1234567890,
			32'sh55555555, 32'shAAAAAAAA
		};
		foreach (directed[i]) begin
			item.value = directed[i];
			item.after_drain = 1'b0;
			values_to_send.push_back(item);
		end
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			if ($urandom_range(0, 99) < 40) begin
				item.value = $urandom;
			end else begin
				n = $urandom_range(1, 10);
				lo = 1;
				for (int d = 1; d < n; d++)
					lo = lo * 10;
				hi = (n == 10) ? 64'd2147483647 : lo * 10 - 1;
				mag = lo + $urandom_range(0, 32'(hi - lo));
				if (n == 1)
					mag = $urandom_range(0, 9);
				item.value = $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
			end
			item.after_drain = (i == 0 || i == 250);
			values_to_send.push_back(item);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (values_to_send.size() != 0 || value_valid)
			@(posedge clk);
		while (text_expected.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d values sent (%0d negative), %0d characters checked, receiver hold-off %0s",
			values_sent, negatives_sent, chars_checked, holdoff_done ? "done" : "not reached");
		$display("%0d mismatches, %0d characters still expected", mismatches, text_expected.size());
		if (mismatches == 0 && text_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
